FILE: hw/rtl/state_vector_gate_apply_defines.svh
// ----------------------------------------------------------------------------
// State vector gate engine: assertion macros
// Shared assertion shorthands for the checker of the gate engine.
// ----------------------------------------------------------------------------
`ifndef STATE_VECTOR_GATE_APPLY_DEFINES_SVH
`define STATE_VECTOR_GATE_APPLY_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SVGA_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define SVGA_ASSERT(name, prop, msg) \
  `SVGA_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

FILE: hw/rtl/svga_pkg.sv
// ----------------------------------------------------------------------------
// State vector gate engine package
// Constants, payload types, command types and rounding shared by all files.
// ----------------------------------------------------------------------------
package svga_pkg;

  localparam int unsigned MAX_QUBITS      = 10;
  localparam int unsigned MAX_GATE_QUBITS = 2;
  localparam int unsigned AW              = MAX_QUBITS;
  localparam int unsigned AMP_DEPTH       = 1 << AW;
  localparam int unsigned CW              = AW + 1;
  localparam int unsigned NW              = $clog2(MAX_QUBITS + 1);
  localparam int unsigned MAT_DEPTH       = 16;
  localparam int unsigned MAT_LIMIT       = (MAX_GATE_QUBITS >= 2) ? 16 : 4;
  localparam int unsigned ACC_W           = 36;

  localparam logic [15:0] ONE_Q14        = 16'h4000;
  localparam logic [3:0]  NUM_QUBITS_RST = 4'd10;

  typedef enum logic [1:0] {
    ACT_WR_AMP = 2'd0,
    ACT_RD_AMP = 2'd1,
    ACT_WR_MAT = 2'd2,
    ACT_APPLY  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TARGET = 2'd1,
    ST_DUP_TARGET = 2'd2,
    ST_BAD_INDEX  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ADDR_INPUT = 2'd0,
    ADDR_GATE  = 2'd1,
    ADDR_CLEAR = 2'd2
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_INPUT = 2'd0,
    WD_CLEAR = 2'd1,
    WD_GATE  = 2'd2
  } wdata_sel_e;

  typedef struct packed {
    action_e            action;
    logic [9:0]         index;
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
    logic [1:0]         num_targets;
    logic [3:0]         target_first;
    logic [3:0]         target_second;
  } in_t;

  typedef struct packed {
    logic signed [15:0] read_re;
    logic signed [15:0] read_im;
    status_e            status;
  } out_t;

  typedef struct packed {
    logic       mem_rd;
    logic       mem_wr;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic [1:0] member;
    logic [1:0] col;
    logic [CW-1:0] base;
    logic       mat_wr;
    logic       item_load;
    logic       mul_en;
    logic       acc_en;
    logic       acc_clr;
    logic       out_load;
    logic       out_read;
    status_e    out_status;
  } cmd_t;

  typedef struct packed {
    logic grp_skip;
  } dp_sts_t;

  // Round a Q8.28 sum to Q2.14 (half up) and saturate to 16 bits.
  function automatic logic [15:0] round_sat(input logic [ACC_W-1:0] acc);
    logic [ACC_W:0]    v;
    logic [ACC_W-14:0] q;
    logic [15:0]       r;
    v = {acc[ACC_W-1], acc} + (ACC_W + 1)'(8192);
    q = v[ACC_W:14];
    if (!q[ACC_W-14] && (|q[ACC_W-14:15])) begin
      r = 16'h7fff;
    end else if (q[ACC_W-14] && !(&q[ACC_W-14:15])) begin
      r = 16'h8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/svga_datapath.sv
// ----------------------------------------------------------------------------
// State vector gate engine datapath
// Amplitude memory, matrix registers, complex multiply-accumulate, result reg.
// ----------------------------------------------------------------------------
module svga_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  svga_pkg::in_t    in_data_i,
  input  svga_pkg::cmd_t   cmd_i,
  output svga_pkg::dp_sts_t sts_o,
  output svga_pkg::out_t   out_data_o
);

  logic [31:0] amp_mem [svga_pkg::AMP_DEPTH];
  logic [31:0] mat_q [svga_pkg::MAT_DEPTH];
  logic signed [15:0] a_re_q [4];
  logic signed [15:0] a_im_q [4];
  logic [3:0] t0_q, t1_q;
  logic       two_q;
  logic signed [31:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [svga_pkg::ACC_W-1:0] acc_re_q, acc_im_q;
  svga_pkg::out_t out_q;

  logic [svga_pkg::AW-1:0] m0, m1, gate_addr, addr;
  logic [31:0] wdata, mat_word;
  logic [3:0]  mat_idx;
  logic signed [15:0] mre, mim;
  logic [svga_pkg::ACC_W-1:0] sum_re, sum_im;

  assign m0 = svga_pkg::AW'(1) << t0_q;
  assign m1 = two_q ? (svga_pkg::AW'(1) << t1_q) : '0;
  assign gate_addr = cmd_i.base[svga_pkg::AW-1:0] | (cmd_i.member[0] ? m0 : '0)
                   | (cmd_i.member[1] ? m1 : '0);
  assign sts_o.grp_skip = |(cmd_i.base[svga_pkg::AW-1:0] & (m0 | m1));

  always_comb begin
    case (cmd_i.addr_sel)
      svga_pkg::ADDR_INPUT: addr = svga_pkg::AW'(in_data_i.index);
      svga_pkg::ADDR_GATE:  addr = gate_addr;
      svga_pkg::ADDR_CLEAR: addr = cmd_i.base[svga_pkg::AW-1:0];
      default:              addr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wdata_sel)
      svga_pkg::WD_INPUT: wdata = {in_data_i.value_re, in_data_i.value_im};
      svga_pkg::WD_CLEAR: wdata = (cmd_i.base == '0) ? {svga_pkg::ONE_Q14, 16'h0000} : '0;
      svga_pkg::WD_GATE:  wdata = {svga_pkg::round_sat(acc_re_q),
                                   svga_pkg::round_sat(acc_im_q)};
      default:            wdata = '0;
    endcase
  end

  // Amplitude memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      amp_mem[addr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      a_re_q[cmd_i.member] <= amp_mem[addr][31:16];
      a_im_q[cmd_i.member] <= amp_mem[addr][15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < svga_pkg::MAT_DEPTH; i++) begin
        mat_q[i] <= '0;
      end
    end else if (cmd_i.mat_wr) begin
      mat_q[in_data_i.index[3:0]] <= {in_data_i.value_re, in_data_i.value_im};
    end
  end

  // A one-qubit gate packs its 2x2 matrix into the first four entries.
  assign mat_idx  = two_q ? {cmd_i.member, cmd_i.col} : {2'b00, cmd_i.member[0], cmd_i.col[0]};
  assign mat_word = mat_q[mat_idx];
  assign mre = mat_word[31:16];
  assign mim = mat_word[15:0];

  assign sum_re = svga_pkg::ACC_W'(p_rr_q) - svga_pkg::ACC_W'(p_ii_q);
  assign sum_im = svga_pkg::ACC_W'(p_ri_q) + svga_pkg::ACC_W'(p_ir_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      t0_q  <= in_data_i.target_first;
      t1_q  <= in_data_i.target_second;
      two_q <= (in_data_i.num_targets == 2'd2);
    end
    if (cmd_i.mul_en) begin
      p_rr_q <= mre * a_re_q[cmd_i.col];
      p_ii_q <= mim * a_im_q[cmd_i.col];
      p_ri_q <= mre * a_im_q[cmd_i.col];
      p_ir_q <= mim * a_re_q[cmd_i.col];
    end
    if (cmd_i.acc_en) begin
      acc_re_q <= (cmd_i.acc_clr ? '0 : acc_re_q) + sum_re;
      acc_im_q <= (cmd_i.acc_clr ? '0 : acc_im_q) + sum_im;
    end
    if (cmd_i.out_load) begin
      out_q.read_re <= cmd_i.out_read ? a_re_q[0] : '0;
      out_q.read_im <= cmd_i.out_read ? a_im_q[0] : '0;
      out_q.status  <= cmd_i.out_status;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hw/rtl/svga_ctrl.sv
// ----------------------------------------------------------------------------
// State vector gate engine controller
// Sequences memory clearing, single accesses and the gate walk over groups.
// ----------------------------------------------------------------------------
module svga_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  svga_pkg::in_t           in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic [svga_pkg::NW-1:0] n_i,
  input  svga_pkg::dp_sts_t       sts_i,
  output svga_pkg::cmd_t          cmd_o
);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_RD_WAIT = 8'b0000_0100,
    S_SCAN    = 8'b0000_1000,
    S_READ    = 8'b0001_0000,
    S_MUL     = 8'b0010_0000,
    S_ACC     = 8'b0100_0000,
    S_WB      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [svga_pkg::CW-1:0] base_q, base_d;
  logic [1:0] member_q, member_d, col_q, col_d;
  logic two_q, two_d, out_valid_q, out_valid_d;

  logic [svga_pkg::CW-1:0] total;
  logic [1:0] gmax;
  logic accept, idx_bad, mat_bad, k_bad, tgt_bad, dup;
  svga_pkg::status_e gate_status;

  assign total = svga_pkg::CW'(1) << n_i;
  assign gmax  = two_q ? 2'd3 : 2'd1;

  assign idx_bad = (32'(in_data_i.index) >> n_i) != 0;
  assign mat_bad = 32'(in_data_i.index) >= svga_pkg::MAT_LIMIT;
  assign k_bad   = (in_data_i.num_targets == 2'd0) || (in_data_i.num_targets > 2'd2)
                || (32'(in_data_i.num_targets) > svga_pkg::MAX_GATE_QUBITS);
  assign tgt_bad = (32'(in_data_i.target_first) >= 32'(n_i))
                || ((in_data_i.num_targets == 2'd2)
                    && (32'(in_data_i.target_second) >= 32'(n_i)));
  assign dup     = (in_data_i.num_targets == 2'd2)
                && (in_data_i.target_first == in_data_i.target_second);

  always_comb begin
    if (k_bad || tgt_bad) begin
      gate_status = svga_pkg::ST_BAD_TARGET;
    end else if (dup) begin
      gate_status = svga_pkg::ST_DUP_TARGET;
    end else begin
      gate_status = svga_pkg::ST_OK;
    end
  end

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    member_d = member_q;
    col_d    = col_q;
    two_d    = two_q;
    cmd_o            = '0;
    cmd_o.addr_sel   = svga_pkg::ADDR_GATE;
    cmd_o.wdata_sel  = svga_pkg::WD_GATE;
    cmd_o.out_status = svga_pkg::ST_OK;
    cmd_o.base       = base_q;
    cmd_o.member     = member_q;
    cmd_o.col        = col_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.mem_wr    = 1'b1;
        cmd_o.addr_sel  = svga_pkg::ADDR_CLEAR;
        cmd_o.wdata_sel = svga_pkg::WD_CLEAR;
        if (&base_q[svga_pkg::AW-1:0]) begin
          base_d  = '0;
          state_d = S_IDLE;
        end else begin
          base_d = base_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.item_load = 1'b1;
          cmd_o.addr_sel  = svga_pkg::ADDR_INPUT;
          cmd_o.wdata_sel = svga_pkg::WD_INPUT;
          cmd_o.member    = 2'd0;
          case (in_data_i.action)
            svga_pkg::ACT_WR_AMP: begin
              cmd_o.out_load = 1'b1;
              if (idx_bad) begin
                cmd_o.out_status = svga_pkg::ST_BAD_INDEX;
              end else begin
                cmd_o.mem_wr = 1'b1;
              end
            end
            svga_pkg::ACT_RD_AMP: begin
              if (idx_bad) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = svga_pkg::ST_BAD_INDEX;
              end else begin
                cmd_o.mem_rd = 1'b1;
                state_d      = S_RD_WAIT;
              end
            end
            svga_pkg::ACT_WR_MAT: begin
              cmd_o.out_load = 1'b1;
              if (mat_bad) begin
                cmd_o.out_status = svga_pkg::ST_BAD_INDEX;
              end else begin
                cmd_o.mat_wr = 1'b1;
              end
            end
            svga_pkg::ACT_APPLY: begin
              if (gate_status != svga_pkg::ST_OK) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = gate_status;
              end else begin
                base_d  = '0;
                two_d   = (in_data_i.num_targets == 2'd2);
                state_d = S_SCAN;
              end
            end
            default: begin
              cmd_o.out_load = 1'b0;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_read = 1'b1;
        state_d        = S_IDLE;
      end
      S_SCAN: begin
        if (base_q == total) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else if (sts_i.grp_skip) begin
          base_d = base_q + 1'b1;
        end else begin
          member_d = 2'd0;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        if (member_q == gmax) begin
          member_d = 2'd0;
          col_d    = 2'd0;
          state_d  = S_MUL;
        end else begin
          member_d = member_q + 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_clr = (col_q == 2'd0);
        if (col_q == gmax) begin
          state_d = S_WB;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_WB: begin
        cmd_o.mem_wr = 1'b1;
        col_d        = 2'd0;
        if (member_q == gmax) begin
          member_d = 2'd0;
          base_d   = base_q + 1'b1;
          state_d  = S_SCAN;
        end else begin
          member_d = member_q + 1'b1;
          state_d  = S_MUL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      base_q      <= '0;
      member_q    <= '0;
      col_q       <= '0;
      two_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      member_q    <= member_d;
      col_q       <= col_d;
      two_q       <= two_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/state_vector_gate_apply.sv
// Amplitude write, matrix write and any error give their word in the cycle after
//   acceptance; an amplitude read goes through the registered memory read first.
// A gate walks every base index once; for each group of g amplitudes it reads the
//   group, then per row multiplies and accumulates each column and writes it back.
// One item is in work at a time; the single-port amplitude memory sets the pace.
// After reset a clearing pass writes basis state zero; no item is taken.
// ----------------------------------------------------------------------------
// State vector gate engine
// Keeps a complex Q2.14 state vector and a gate matrix, and applies one- and
// two-qubit gates to the vector in place.
// ----------------------------------------------------------------------------
module state_vector_gate_apply (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  svga_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output svga_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [3:0]     cfg_data_i
);

  // The qubit count register is always writable; change it only while idle (unenforced).
  logic [3:0] num_qubits_q;
  logic [svga_pkg::NW-1:0] n_eff;
  svga_pkg::cmd_t    cmd;
  svga_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_qubits_q <= svga_pkg::NUM_QUBITS_RST;
    end else if (cfg_valid_i) begin
      num_qubits_q <= cfg_data_i;
    end
  end

  // A count of zero behaves as one qubit, and counts beyond the store are clamped.
  always_comb begin
    if (num_qubits_q == 4'd0) begin
      n_eff = svga_pkg::NW'(1);
    end else if (32'(num_qubits_q) > svga_pkg::MAX_QUBITS) begin
      n_eff = svga_pkg::NW'(svga_pkg::MAX_QUBITS);
    end else begin
      n_eff = svga_pkg::NW'(num_qubits_q);
    end
  end

  // The controller decides every step; the datapath holds all storage and arithmetic.
  // Each gate group is read into four amplitude registers, so the rows can be
  // written back one by one without disturbing the columns still being summed.
  svga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .n_i        (n_eff),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  svga_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

FILE: hw/rtl/svga_checker.sv
// ----------------------------------------------------------------------------
// State vector gate engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "state_vector_gate_apply_defines.svh"

module svga_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input svga_pkg::out_t out_data_o
);

  logic out_blocked, in_taken, out_err, out_zero;

  assign out_blocked = out_valid_o && out_stall_i;
  assign in_taken    = in_valid_i && !in_stall_o;
  assign out_err     = out_valid_o && (out_data_o.status != svga_pkg::ST_OK);
  assign out_zero    = (out_data_o.read_re == 16'sd0) && (out_data_o.read_im == 16'sd0);

  `SVGA_ASSERT(a_out_hold, out_blocked |=> out_valid_o && $stable(out_data_o), "word changed")
  `SVGA_ASSERT(a_err_zero, out_err |-> out_zero, "error word carries read data")
  `SVGA_ASSERT(a_no_overrun, in_taken |-> !out_blocked, "item taken while word is blocked")

endmodule

bind state_vector_gate_apply svga_checker u_svga_checker (.*);
